>>> sv/grb_pkg.sv
`timescale 1ns / 1ps
// grb_pkg: shared types, opcodes, register indexes and button map
// of the gamepad report builder; no dependencies
package grb_pkg;

  localparam int BYTE_IDX_W = 5;
  localparam int VALUE_W    = 32;
  localparam int AXIS_W     = 16;

  localparam logic [2:0] OP_BUTTON    = 3'd0;
  localparam logic [2:0] OP_TRIGGER   = 3'd1;
  localparam logic [2:0] OP_STICK     = 3'd2;
  localparam logic [2:0] OP_AXIS      = 3'd3;
  localparam logic [2:0] OP_DPAD      = 3'd4;
  localparam logic [2:0] OP_STICK_DIG = 3'd5;
  localparam logic [2:0] OP_CLEAR     = 3'd6;
  localparam logic [2:0] OP_SEND      = 3'd7;

  localparam logic [2:0] REG_TRIG_LO  = 3'd0;
  localparam logic [2:0] REG_TRIG_HI  = 3'd1;
  localparam logic [2:0] REG_STICK_LO = 3'd2;
  localparam logic [2:0] REG_STICK_HI = 3'd3;
  localparam logic [2:0] REG_AUTO     = 3'd4;

  localparam logic [4:0] BTN_LAST     = 5'd18;
  localparam logic [4:0] BTN_TRIG_L   = 5'd15;
  localparam logic [4:0] BTN_TRIG_R   = 5'd16;

  localparam logic [AXIS_W-1:0] STICK_MIN = 16'h8000;
  localparam logic [AXIS_W-1:0] STICK_MAX = 16'h7fff;
  localparam logic [AXIS_W-1:0] TRIG_MIN  = 16'h0000;
  localparam logic [AXIS_W-1:0] TRIG_MAX  = 16'h00ff;

  typedef struct packed {
    logic start;
    logic is_stick;
  } scale_req_t;

  function automatic logic [BYTE_IDX_W-1:0] btn_pos(input logic [4:0] id);
    logic [BYTE_IDX_W-1:0] p;
    case (id)
      5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6: p = 5'd3;
      default: p = 5'd2;
    endcase
    return p;
  endfunction

  function automatic logic [2:0] btn_bit(input logic [4:0] id);
    logic [2:0] b;
    case (id)
      5'd0:  b = 3'd2;
      5'd1:  b = 3'd4;
      5'd2:  b = 3'd5;
      5'd3:  b = 3'd6;
      5'd4:  b = 3'd7;
      5'd5:  b = 3'd0;
      5'd6:  b = 3'd1;
      5'd7:  b = 3'd5;
      5'd8:  b = 3'd4;
      5'd9:  b = 3'd6;
      5'd10: b = 3'd7;
      5'd11: b = 3'd0;
      5'd12: b = 3'd1;
      5'd13: b = 3'd2;
      5'd14: b = 3'd3;
      5'd17: b = 3'd6;
      5'd18: b = 3'd7;
      default: b = 3'd0;
    endcase
    return b;
  endfunction

endpackage

>>> sv/grb_ram.sv
`timescale 1ns / 1ps
// grb_ram: generic single-write, single-read ram with registered read
// no dependencies
module grb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 20
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/grb_rescale.sv
`timescale 1ns / 1ps
// grb_rescale: clamp and linear rescale of one raw value, multiply then
// restoring divide one quotient bit per cycle; uses grb_pkg
module grb_rescale import grb_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  scale_req_t                req,
  input  logic signed [VALUE_W-1:0] value,
  input  logic signed [VALUE_W-1:0] range_lo,
  input  logic signed [VALUE_W-1:0] range_hi,
  output logic                      done,
  output logic [AXIS_W-1:0]         result
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_DIV  = 2'd2;
  localparam logic [1:0] PH_FIN  = 2'd3;

  logic [1:0]         ph_r, ph_nxt;
  logic               done_r, done_nxt;
  logic               stick_r, stick_nxt;
  logic [3:0]         step_r, step_nxt;
  logic [VALUE_W-1:0] diff_r, diff_nxt;
  logic [VALUE_W-1:0] den_r, den_nxt;
  logic [VALUE_W-1:0] rem_r, rem_nxt;
  logic [AXIS_W-1:0]  quo_r, quo_nxt;
  logic [AXIS_W-1:0]  res_r, res_nxt;
  logic [AXIS_W-1:0]  span;
  logic [47:0]        prod;
  logic [VALUE_W:0]   trial;
  logic               ge;

  assign span  = stick_r ? 16'hffff : 16'h00ff;
  assign prod  = 48'(diff_r) * 48'(span);
  assign trial = {rem_r, quo_r[AXIS_W-1]};
  assign ge    = trial >= {1'b0, den_r};

  always_comb begin
    ph_nxt    = ph_r;
    done_nxt  = 1'b0;
    stick_nxt = stick_r;
    step_nxt  = step_r;
    diff_nxt  = diff_r;
    den_nxt   = den_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    res_nxt   = res_r;
    case (ph_r)
      PH_IDLE: begin
        if (req.start) begin
          stick_nxt = req.is_stick;
          if (value <= range_lo) begin
            res_nxt  = req.is_stick ? STICK_MIN : TRIG_MIN;
            done_nxt = 1'b1;
          end else if (value >= range_hi) begin
            res_nxt  = req.is_stick ? STICK_MAX : TRIG_MAX;
            done_nxt = 1'b1;
          end else begin
            diff_nxt = VALUE_W'(value - range_lo);
            den_nxt  = VALUE_W'(range_hi - range_lo);
            ph_nxt   = PH_MUL;
          end
        end
      end
      PH_MUL: begin
        rem_nxt  = prod[47:16];
        quo_nxt  = prod[15:0];
        step_nxt = 4'd0;
        ph_nxt   = PH_DIV;
      end
      PH_DIV: begin
        rem_nxt  = ge ? VALUE_W'(trial - {1'b0, den_r}) : trial[VALUE_W-1:0];
        quo_nxt  = {quo_r[AXIS_W-2:0], ge};
        step_nxt = step_r + 4'd1;
        if (step_r == 4'd15) begin
          ph_nxt = PH_FIN;
        end
      end
      PH_FIN: begin
        res_nxt  = stick_r ? {~quo_r[AXIS_W-1], quo_r[AXIS_W-2:0]} : quo_r;
        done_nxt = 1'b1;
        ph_nxt   = PH_IDLE;
      end
      default: ph_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_IDLE;
      done_r <= 1'b0;
    end else begin
      ph_r   <= ph_nxt;
      done_r <= done_nxt;
    end
    stick_r <= stick_nxt;
    step_r  <= step_nxt;
    diff_r  <= diff_nxt;
    den_r   <= den_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    res_r   <= res_nxt;
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

>>> sv/gamepad_report_builder_unit.sv
`timescale 1ns / 1ps
// gamepad_report_builder_unit: top level of the gamepad report builder
// uses grb_pkg, grb_ram and grb_rescale
//
// The report lives in a one-read one-write ram; each event reads the one to
// four bytes it touches and writes back those it changes, a read state and
// then a modify state per byte. Analog events first pass the rescale unit,
// where a clamped value skips the multiply and divide; a both-axes event
// rescales two values. A release-all writes one byte a cycle. A report run
// streams REPORT_LENGTH items at one per cycle while out_ready holds. One
// event is taken at a time; in_ready is high only between events. No
// clearing pass is needed after reset.
module gamepad_report_builder_unit import grb_pkg::*; #(
  parameter int REPORT_LENGTH = 20
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            in_opcode,
  input  logic [4:0]            in_control_select,
  input  logic                  in_axis_select,
  input  logic                  in_pressed,
  input  logic signed [31:0]    in_value_a,
  input  logic signed [31:0]    in_value_b,
  input  logic                  in_invert_axis,
  input  logic                  in_dir_up,
  input  logic                  in_dir_down,
  input  logic                  in_dir_left,
  input  logic                  in_dir_right,
  input  logic                  in_socd_enable,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_report_byte,
  output logic [BYTE_IDX_W-1:0] out_byte_index,
  output logic                  out_last_byte,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [31:0]           cfg_data
);

  localparam int AW = $clog2(REPORT_LENGTH);
  localparam int CW = $clog2(REPORT_LENGTH + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(REPORT_LENGTH - 1);
  localparam logic [CW-1:0] LEN_C     = CW'(REPORT_LENGTH);
  localparam logic [7:0]    LEN_BYTE  = 8'(REPORT_LENGTH);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SCA  = 4'd1;
  localparam logic [3:0] S_SCB  = 4'd2;
  localparam logic [3:0] S_RD   = 4'd3;
  localparam logic [3:0] S_MOD  = 4'd4;
  localparam logic [3:0] S_CLR  = 4'd5;
  localparam logic [3:0] S_FIN  = 4'd6;
  localparam logic [3:0] S_EMIT = 4'd7;

  logic [3:0]         state_r, state_nxt;
  logic [1:0]         k_r, k_nxt;
  logic [AW-1:0]      clr_r, clr_nxt;
  logic [2:0]         op_r, op_nxt;
  logic [4:0]         sel_r, sel_nxt;
  logic               axis_r, axis_nxt;
  logic               pressed_r, pressed_nxt;
  logic               inv_r, inv_nxt;
  logic               up_r, up_nxt, down_r, down_nxt;
  logic               left_r, left_nxt, right_r, right_nxt;
  logic signed [31:0] vb_r, vb_nxt;
  logic [AXIS_W-1:0]  x_r, x_nxt, y_r, y_nxt;
  logic               changed_r, changed_nxt;
  logic               pending_r, pending_nxt;
  logic [CW-1:0]      em_idx_r, em_idx_nxt;
  logic               rd_pend_r, rd_pend_nxt;
  logic [AW-1:0]      pend_idx_r, pend_idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_byte_r, out_byte_nxt;
  logic [AW-1:0]      out_idx_r, out_idx_nxt;
  logic               out_last_r, out_last_nxt;

  logic signed [31:0] trig_lo_r, trig_hi_r, stick_lo_r, stick_hi_r;
  logic               auto_r;

  logic [REPORT_LENGTH-1:0] valid_r;
  logic                     rvld_r;
  logic [7:0]               rdef_r;

  logic          accept;
  logic          up_c, down_c, left_c, right_c;
  logic          sel_ok_in;
  logic [AW-1:0] base;
  logic [AW-1:0] plan_addr;
  logic [1:0]    plan_last;
  logic [7:0]    cur_byte, new_byte;
  logic [7:0]    mask;
  logic          mem_we, mem_re, load;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, ram_rdata;
  logic          always_op, do_emit;

  scale_req_t         sreq;
  logic signed [31:0] sval, slo, shi;
  logic               sdone;
  logic [AXIS_W-1:0]  sres;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);

  assign up_c      = in_dir_up;
  assign down_c    = in_dir_down && !(in_socd_enable && in_dir_up);
  assign left_c    = in_dir_left && !(in_socd_enable && in_dir_right);
  assign right_c   = in_dir_right && !(in_socd_enable && in_dir_left);
  assign sel_ok_in = (in_control_select[4:1] == 4'd0);

  assign cur_byte = rvld_r ? ram_rdata : rdef_r;
  assign base     = sel_r[0] ? AW'(10) : AW'(6);
  assign mask     = 8'(1) << btn_bit(sel_r);

  // byte plan of the current event
  always_comb begin
    plan_addr = AW'(2);
    plan_last = 2'd0;
    new_byte  = cur_byte;
    case (op_r)
      OP_BUTTON: begin
        if (sel_r == BTN_TRIG_L || sel_r == BTN_TRIG_R) begin
          plan_addr = (sel_r == BTN_TRIG_R) ? AW'(5) : AW'(4);
          new_byte  = pressed_r ? 8'hff : 8'h00;
        end else begin
          plan_addr = AW'(btn_pos(sel_r));
          new_byte  = pressed_r ? (cur_byte | mask) : (cur_byte & ~mask);
        end
      end
      OP_TRIGGER: begin
        plan_addr = sel_r[0] ? AW'(5) : AW'(4);
        new_byte  = x_r[7:0];
      end
      OP_STICK, OP_STICK_DIG: begin
        plan_addr = base + AW'(k_r);
        plan_last = 2'd3;
        case (k_r)
          2'd0: new_byte = x_r[7:0];
          2'd1: new_byte = x_r[15:8];
          2'd2: new_byte = y_r[7:0];
          default: new_byte = y_r[15:8];
        endcase
      end
      OP_AXIS: begin
        plan_addr = base + (axis_r ? AW'(2) : AW'(0)) + AW'(k_r);
        plan_last = 2'd1;
        new_byte  = k_r[0] ? x_r[15:8] : x_r[7:0];
      end
      OP_DPAD: begin
        plan_addr = AW'(2);
        new_byte  = {cur_byte[7:4], right_r, left_r, down_r, up_r};
      end
      default: begin
        plan_addr = AW'(2);
      end
    endcase
  end

  assign always_op = (op_r == OP_STICK) || (op_r == OP_DPAD) ||
                     (op_r == OP_STICK_DIG) || (op_r == OP_CLEAR);
  assign do_emit   = pending_r && ((op_r == OP_SEND) ||
                     (auto_r && (changed_r || always_op)));
  assign load      = rd_pend_r && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    clr_nxt       = clr_r;
    op_nxt        = op_r;
    sel_nxt       = sel_r;
    axis_nxt      = axis_r;
    pressed_nxt   = pressed_r;
    inv_nxt       = inv_r;
    up_nxt        = up_r;
    down_nxt      = down_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    vb_nxt        = vb_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    changed_nxt   = changed_r;
    pending_nxt   = pending_r;
    em_idx_nxt    = em_idx_r;
    rd_pend_nxt   = rd_pend_r;
    pend_idx_nxt  = pend_idx_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_idx_nxt   = out_idx_r;
    out_last_nxt  = out_last_r;
    mem_we        = 1'b0;
    mem_waddr     = plan_addr;
    mem_wdata     = new_byte;
    mem_re        = 1'b0;
    mem_raddr     = plan_addr;
    sreq.start    = 1'b0;
    sreq.is_stick = 1'b1;
    sval          = vb_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = cur_byte;
      out_idx_nxt   = pend_idx_r;
      out_last_nxt  = (pend_idx_r == LAST_ADDR);
      rd_pend_nxt   = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        sval          = in_value_a;
        sreq.is_stick = (in_opcode != OP_TRIGGER);
        if (accept) begin
          op_nxt      = in_opcode;
          sel_nxt     = in_control_select;
          axis_nxt    = in_axis_select;
          pressed_nxt = in_pressed;
          inv_nxt     = in_invert_axis;
          up_nxt      = up_c;
          down_nxt    = down_c;
          left_nxt    = left_c;
          right_nxt   = right_c;
          vb_nxt      = in_value_b;
          changed_nxt = 1'b0;
          k_nxt       = 2'd0;
          case (in_opcode)
            OP_BUTTON: begin
              if (in_control_select <= BTN_LAST) begin
                state_nxt = S_RD;
              end
            end
            OP_TRIGGER, OP_STICK, OP_AXIS: begin
              if (sel_ok_in) begin
                sreq.start = 1'b1;
                state_nxt  = S_SCA;
              end
            end
            OP_DPAD: state_nxt = S_RD;
            OP_STICK_DIG: begin
              if (sel_ok_in) begin
                x_nxt     = (left_c == right_c) ? 16'h0000 :
                            (left_c ? STICK_MIN : STICK_MAX);
                y_nxt     = (up_c == down_c) ? 16'h0000 :
                            (up_c ? STICK_MAX : STICK_MIN);
                state_nxt = S_RD;
              end
            end
            OP_CLEAR: begin
              clr_nxt   = AW'(2);
              state_nxt = S_CLR;
            end
            default: state_nxt = S_FIN;
          endcase
        end
      end
      S_SCA: begin
        if (sdone) begin
          x_nxt = (op_r == OP_AXIS && inv_r) ? ~sres : sres;
          if (op_r == OP_STICK) begin
            sreq.start = 1'b1;
            state_nxt  = S_SCB;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_SCB: begin
        if (sdone) begin
          y_nxt     = sres;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        mem_re    = 1'b1;
        state_nxt = S_MOD;
      end
      S_MOD: begin
        if (new_byte != cur_byte) begin
          mem_we      = 1'b1;
          changed_nxt = 1'b1;
          pending_nxt = 1'b1;
        end
        if (k_r == plan_last) begin
          state_nxt = S_FIN;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = S_RD;
        end
      end
      S_CLR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_r;
        mem_wdata   = 8'h00;
        pending_nxt = 1'b1;
        if (clr_r == LAST_ADDR) begin
          state_nxt = S_FIN;
        end else begin
          clr_nxt = clr_r + AW'(1);
        end
      end
      S_FIN: begin
        if (do_emit) begin
          pending_nxt = 1'b0;
          em_idx_nxt  = '0;
          state_nxt   = S_EMIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        mem_raddr = em_idx_r[AW-1:0];
        if (em_idx_r != LEN_C && (!rd_pend_r || load)) begin
          mem_re       = 1'b1;
          rd_pend_nxt  = 1'b1;
          pend_idx_nxt = em_idx_r[AW-1:0];
          em_idx_nxt   = em_idx_r + CW'(1);
        end else if (em_idx_r == LEN_C && !rd_pend_r) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign slo = sreq.is_stick ? stick_lo_r : trig_lo_r;
  assign shi = sreq.is_stick ? stick_hi_r : trig_hi_r;

  grb_rescale u_rescale (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (sreq),
    .value    (sval),
    .range_lo (slo),
    .range_hi (shi),
    .done     (sdone),
    .result   (sres)
  );

  grb_ram #(
    .WIDTH (8),
    .DEPTH (REPORT_LENGTH)
  ) u_report_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pending_r   <= 1'b1;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      pending_r   <= pending_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (mem_we) begin
        valid_r[mem_waddr] <= 1'b1;
      end
    end
    k_r        <= k_nxt;
    clr_r      <= clr_nxt;
    op_r       <= op_nxt;
    sel_r      <= sel_nxt;
    axis_r     <= axis_nxt;
    pressed_r  <= pressed_nxt;
    inv_r      <= inv_nxt;
    up_r       <= up_nxt;
    down_r     <= down_nxt;
    left_r     <= left_nxt;
    right_r    <= right_nxt;
    vb_r       <= vb_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    changed_r  <= changed_nxt;
    em_idx_r   <= em_idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    out_byte_r <= out_byte_nxt;
    out_idx_r  <= out_idx_nxt;
    out_last_r <= out_last_nxt;
    if (mem_re) begin
      rvld_r <= valid_r[mem_raddr];
      rdef_r <= (mem_raddr == AW'(1)) ? LEN_BYTE : 8'h00;
    end
  end

  // configuration registers, range pairs keep low below high
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_lo_r  <= 32'sd0;
      trig_hi_r  <= 32'sd255;
      stick_lo_r <= -32'sd32768;
      stick_hi_r <= 32'sd32767;
      auto_r     <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TRIG_LO: begin
          if ($signed(cfg_data) < trig_hi_r) trig_lo_r <= $signed(cfg_data);
        end
        REG_TRIG_HI: begin
          if (trig_lo_r < $signed(cfg_data)) trig_hi_r <= $signed(cfg_data);
        end
        REG_STICK_LO: begin
          if ($signed(cfg_data) < stick_hi_r) stick_lo_r <= $signed(cfg_data);
        end
        REG_STICK_HI: begin
          if (stick_lo_r < $signed(cfg_data)) stick_hi_r <= $signed(cfg_data);
        end
        REG_AUTO: auto_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_report_byte = out_byte_r;
  assign out_byte_index  = BYTE_IDX_W'(out_idx_r);
  assign out_last_byte   = out_last_r;

  a_rd_only_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> (state_r == S_EMIT))
    else $error("report read outstanding outside a run");

  a_no_write_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> !mem_we)
    else $error("report written during a run");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid &&
      $stable({out_report_byte, out_byte_index, out_last_byte})))
    else $error("waiting item dropped or changed");

  a_pending_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && state_nxt == S_EMIT) |=> !pending_r)
    else $error("pending still set after starting a run");

endmodule
